// File: src/tpaf_pkg.sv
// Shared constants and types for the thyristor phase-angle firing block.
// No dependencies; used by tpaf_delay and thyristor_phase_angle_firing_top.
package tpaf_pkg;

  localparam int unsigned HalfW  = 16;  // half period, width, delay, tick counter
  localparam int unsigned AngleW = 8;
  localparam int unsigned CountW = 32;
  localparam int unsigned ProdW  = HalfW + AngleW;

  localparam logic [HalfW-1:0] MinDelayUs  = 16'd10;
  localparam logic [HalfW-1:0] GuardUs     = 16'd50;
  localparam logic [HalfW-1:0] WidthReset  = 16'd100;

  // x / 180 == (x >> 2) / 45; for a 22-bit value (y * RecipMul) >> RecipShift is exact
  localparam int unsigned      QuarterW   = ProdW - 2;
  localparam int unsigned      RecipW     = 23;
  localparam int unsigned      RecipShift = 28;
  localparam logic [RecipW-1:0] RecipMul  = 23'd5965233;  // ceil(2^28 / 45)

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgEnable = 2'd0,
    CfgWidth  = 2'd1,
    CfgAngle  = 2'd2
  } cfg_idx_e;

  // compare points armed by a zero crossing
  typedef struct packed {
    logic             ok;      // half period long enough to fire
    logic [HalfW-1:0] delay;   // clamped firing delay
    logic [HalfW-1:0] end_at;  // delay + width, wraps
  } arm_t;

endpackage

// File: src/tpaf_delay.sv
// Firing delay for one zero crossing: divide by 180, clamp, end point.
// Depends on tpaf_pkg; the half period times angle product comes in registered.
module tpaf_delay (
  input  logic [tpaf_pkg::HalfW-1:0] half_i,
  input  logic [tpaf_pkg::ProdW-1:0] prod_i,
  input  logic [tpaf_pkg::HalfW-1:0] width_i,
  output tpaf_pkg::arm_t             arm_o
);

  logic [tpaf_pkg::QuarterW-1:0]                  quarter;
  logic [tpaf_pkg::QuarterW+tpaf_pkg::RecipW-1:0] scaled;
  logic [tpaf_pkg::HalfW:0]                       quot;
  logic [tpaf_pkg::HalfW:0]                       need;
  logic [tpaf_pkg::HalfW:0]                       lim;
  logic [tpaf_pkg::HalfW:0]                       lo_clamped;
  logic [tpaf_pkg::HalfW-1:0]                     delay;

  // product / 180 by reciprocal multiply
  assign quarter = prod_i[tpaf_pkg::ProdW-1:2];
  assign scaled  = quarter * tpaf_pkg::RecipMul;
  assign quot    = scaled[tpaf_pkg::QuarterW+tpaf_pkg::RecipW-1:tpaf_pkg::RecipShift];

  // guard check and upper bound
  assign need = {1'b0, width_i} + {1'b0, tpaf_pkg::GuardUs};
  assign lim  = {1'b0, half_i} - need;

  // raise to the minimum first, then the upper bound wins
  always_comb begin
    lo_clamped = quot;
    if (quot < {1'b0, tpaf_pkg::MinDelayUs}) begin
      lo_clamped = {1'b0, tpaf_pkg::MinDelayUs};
    end
    if (lo_clamped > lim) begin
      delay = lim[tpaf_pkg::HalfW-1:0];
    end else begin
      delay = lo_clamped[tpaf_pkg::HalfW-1:0];
    end
  end

  assign arm_o.ok     = ({1'b0, half_i} > need);
  assign arm_o.delay  = delay;
  assign arm_o.end_at = delay + width_i;

endmodule

// File: src/thyristor_phase_angle_firing_top.sv
// Top level of the thyristor phase-angle gate-pulse generator.
// Depends on tpaf_pkg and tpaf_delay.
//
//  channel  signals                                   direction
//  -------  ----------------------------------------  ---------
//  in       in_valid_i, in_stall_o, op_i, half_period_us_i      in
//  out      out_valid_o, out_stall_i, gate_o, delay_us_o,
//           fire_count_o, end_count_o, restart_count_o          out
//  cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i                    in
//
// One item per cycle while the output is not stalled.
// Stage one registers the item with half_period * angle, stage two divides
// by 180, clamps, updates the timing state and holds the result.
// A stalled result holds; stage one still takes one item meanwhile.
// Reset clears all timing state and counters; width resets to 100 us.
module thyristor_phase_angle_firing_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic [tpaf_pkg::HalfW-1:0]          half_period_us_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                gate_o,
  output logic [tpaf_pkg::HalfW-1:0]          delay_us_o,
  output logic [tpaf_pkg::CountW-1:0]         fire_count_o,
  output logic [tpaf_pkg::CountW-1:0]         end_count_o,
  output logic [tpaf_pkg::CountW-1:0]         restart_count_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_idx_i,
  input  logic [tpaf_pkg::HalfW-1:0]          cfg_wdata_i
);

  // configuration
  logic                          enable_q;
  logic [tpaf_pkg::HalfW-1:0]    width_q;
  logic [tpaf_pkg::AngleW-1:0]   angle_q;

  // stage one
  logic                          a_valid_q;
  logic                          a_op_q;
  logic [tpaf_pkg::HalfW-1:0]    a_half_q;
  logic [tpaf_pkg::ProdW-1:0]    a_prod_q;

  // timing state and result
  logic                          out_valid_q;
  logic                          running_q, running_d;
  logic                          gate_q, gate_d;
  logic [tpaf_pkg::HalfW-1:0]    tick_q, tick_d;
  logic [tpaf_pkg::HalfW-1:0]    fire_at_q, fire_at_d;
  logic [tpaf_pkg::HalfW-1:0]    end_at_q, end_at_d;
  logic [tpaf_pkg::HalfW-1:0]    delay_q, delay_d;
  logic [tpaf_pkg::CountW-1:0]   fires_q, fires_d;
  logic [tpaf_pkg::CountW-1:0]   ends_q, ends_d;
  logic [tpaf_pkg::CountW-1:0]   restarts_q, restarts_d;

  logic                          out_free;
  logic                          adv;
  logic                          take;
  logic [tpaf_pkg::HalfW-1:0]    tick_inc;
  tpaf_pkg::arm_t                arm;

  // handshake
  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = a_valid_q && out_free;
  assign in_stall_o = a_valid_q && !out_free;
  assign take       = in_valid_i && !in_stall_o;

  // stage one: item and product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (take) begin
      a_valid_q <= 1'b1;
    end else if (adv) begin
      a_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      a_op_q   <= op_i;
      a_half_q <= half_period_us_i;
      a_prod_q <= half_period_us_i * angle_q;
    end
  end

  tpaf_delay u_delay (
    .half_i  (a_half_q),
    .prod_i  (a_prod_q),
    .width_i (width_q),
    .arm_o   (arm)
  );

  // next timing state for the item in stage one
  assign tick_inc = tick_q + 1'b1;

  always_comb begin
    running_d  = running_q;
    gate_d     = gate_q;
    tick_d     = tick_q;
    fire_at_d  = fire_at_q;
    end_at_d   = end_at_q;
    delay_d    = delay_q;
    fires_d    = fires_q;
    ends_d     = ends_q;
    restarts_d = restarts_q;
    if (a_op_q) begin
      // zero crossing
      if (enable_q && arm.ok) begin
        delay_d   = arm.delay;
        fire_at_d = arm.delay;
        end_at_d  = arm.end_at;
        tick_d    = '0;
        running_d = 1'b1;
        if (running_q) begin
          restarts_d = restarts_q + 1'b1;
        end
      end
    end else if (running_q) begin
      // microsecond tick
      tick_d = tick_inc;
      if (tick_inc == fire_at_q) begin
        gate_d  = 1'b1;
        fires_d = fires_q + 1'b1;
      end
      if (tick_inc == end_at_q) begin
        gate_d    = 1'b0;
        ends_d    = ends_q + 1'b1;
        running_d = 1'b0;
      end
    end
  end

  // state registers, also the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      enable_q    <= 1'b0;
      width_q     <= tpaf_pkg::WidthReset;
      angle_q     <= '0;
      running_q   <= 1'b0;
      gate_q      <= 1'b0;
      tick_q      <= '0;
      fire_at_q   <= '0;
      end_at_q    <= '0;
      delay_q     <= '0;
      fires_q     <= '0;
      ends_q      <= '0;
      restarts_q  <= '0;
    end else begin
      if (out_free) begin
        out_valid_q <= a_valid_q;
      end
      if (adv) begin
        running_q  <= running_d;
        gate_q     <= gate_d;
        tick_q     <= tick_d;
        fire_at_q  <= fire_at_d;
        end_at_q   <= end_at_d;
        delay_q    <= delay_d;
        fires_q    <= fires_d;
        ends_q     <= ends_d;
        restarts_q <= restarts_d;
      end
      // configuration writes must arrive only while idle; the block does not enforce it
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tpaf_pkg::CfgEnable: begin
            enable_q <= cfg_wdata_i[0];
            if (!cfg_wdata_i[0]) begin
              running_q <= 1'b0;
              gate_q    <= 1'b0;
            end
          end
          tpaf_pkg::CfgWidth: width_q <= cfg_wdata_i;
          tpaf_pkg::CfgAngle: angle_q <= cfg_wdata_i[tpaf_pkg::AngleW-1:0];
          default: ;
        endcase
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign gate_o          = gate_q;
  assign delay_us_o      = delay_q;
  assign fire_count_o    = fires_q;
  assign end_count_o     = ends_q;
  assign restart_count_o = restarts_q;

  // the gate is only ever high during a running pulse sequence
  assert property (@(posedge clk_i) disable iff (!rst_ni) gate_q |-> running_q)
    else $error("gate high while timing stopped");

  // stage one never stalls the input while empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) !a_valid_q |-> !in_stall_o)
    else $error("input stalled with empty stage");

  // counters move only when an item reaches the result register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> ($stable(fires_q) && $stable(ends_q) && $stable(restarts_q)))
    else $error("counter changed without an item");

  // an armed crossing always yields a nonzero delay
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && a_op_q && enable_q && arm.ok) |=> (delay_q != '0))
    else $error("zero firing delay armed");

endmodule

// File: bench/tb_thyristor_phase_angle_firing_top.sv
// Self-checking testbench for thyristor_phase_angle_firing_top: directed firing cases,
// then random tick/crossing traffic under four idle/stall mixes, checked by a predictor.
// Depends on tpaf_pkg and the RTL under src/.
module tb_thyristor_phase_angle_firing_top;

  localparam logic        OpTick     = 1'b0;
  localparam logic        OpCrossing = 1'b1;
  localparam logic [1:0]  CfgUnused  = 2'd3;   // no register behind this index
  localparam logic [31:0] DegPerHalf = 32'd180;

  // gate status reported after every item
  typedef struct packed {
    logic                        gate;
    logic [tpaf_pkg::HalfW-1:0]  delay;
    logic [tpaf_pkg::CountW-1:0] fires;
    logic [tpaf_pkg::CountW-1:0] ends;
    logic [tpaf_pkg::CountW-1:0] restarts;
  } firing_status_t;

  logic                        clk_i            = 1'b0;
  logic                        rst_ni           = 1'b0;
  logic                        in_valid_i       = 1'b0;
  logic                        in_stall_o;
  logic                        op_i             = OpTick;
  logic [tpaf_pkg::HalfW-1:0]  half_period_us_i = '0;
  logic                        out_valid_o;
  logic                        out_stall_i      = 1'b0;
  logic                        gate_o;
  logic [tpaf_pkg::HalfW-1:0]  delay_us_o;
  logic [tpaf_pkg::CountW-1:0] fire_count_o;
  logic [tpaf_pkg::CountW-1:0] end_count_o;
  logic [tpaf_pkg::CountW-1:0] restart_count_o;
  logic                        cfg_we_i         = 1'b0;
  logic [1:0]                  cfg_idx_i        = '0;
  logic [tpaf_pkg::HalfW-1:0]  cfg_wdata_i      = '0;

  // predictor copy of registers and timing state
  logic                        en_r;
  logic [tpaf_pkg::HalfW-1:0]  width_r;
  logic [tpaf_pkg::AngleW-1:0] angle_r;
  logic                        run_r;
  logic [tpaf_pkg::HalfW-1:0]  us_count;
  logic [tpaf_pkg::HalfW-1:0]  fire_pt;
  logic [tpaf_pkg::HalfW-1:0]  end_pt;
  logic                        gate_r;
  logic [tpaf_pkg::HalfW-1:0]  delay_r;
  logic [tpaf_pkg::CountW-1:0] fire_total;
  logic [tpaf_pkg::CountW-1:0] end_total;
  logic [tpaf_pkg::CountW-1:0] restart_total;

  firing_status_t status_q[$];

  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  int unsigned items_sent    = 0;
  int unsigned crossings     = 0;
  int unsigned results_seen  = 0;
  int unsigned mismatches    = 0;

  thyristor_phase_angle_firing_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .op_i            (op_i),
    .half_period_us_i(half_period_us_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .gate_o          (gate_o),
    .delay_us_o      (delay_us_o),
    .fire_count_o    (fire_count_o),
    .end_count_o     (end_count_o),
    .restart_count_o (restart_count_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_wdata_i     (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // receiver stall pattern
  initial begin
    forever begin
      @(posedge clk_i);
      out_stall_i <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("timeout: %0d results still pending", status_q.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void reset_firing_state();
    en_r          = 1'b0;
    width_r       = tpaf_pkg::WidthReset;
    angle_r       = '0;
    run_r         = 1'b0;
    us_count      = '0;
    fire_pt       = '0;
    end_pt        = '0;
    gate_r        = 1'b0;
    delay_r       = '0;
    fire_total    = '0;
    end_total     = '0;
    restart_total = '0;
  endfunction

  function automatic void apply_config(input logic [1:0] idx,
                                       input logic [tpaf_pkg::HalfW-1:0] val);
    case (idx)
      tpaf_pkg::CfgEnable: begin
        en_r = val[0];
        if (!en_r) begin
          run_r  = 1'b0;
          gate_r = 1'b0;
        end
      end
      tpaf_pkg::CfgWidth: width_r = val;
      tpaf_pkg::CfgAngle: angle_r = val[tpaf_pkg::AngleW-1:0];
      default: ;
    endcase
  endfunction

  // advance timing state by one item and queue the status it leaves behind
  function automatic void advance_firing(input logic op,
                                         input logic [tpaf_pkg::HalfW-1:0] half);
    logic [31:0] half32;
    logic [31:0] width32;
    logic [31:0] bound;
    logic [31:0] dly;
    firing_status_t st;
    half32  = half;
    width32 = width_r;
    if (op == OpCrossing) begin
      if (en_r && half32 > width32 + tpaf_pkg::GuardUs) begin
        bound = half32 - width32 - tpaf_pkg::GuardUs;
        dly   = (half32 * angle_r) / DegPerHalf;
        if (dly < tpaf_pkg::MinDelayUs) dly = tpaf_pkg::MinDelayUs;
        if (dly > bound) dly = bound;
        delay_r = dly[tpaf_pkg::HalfW-1:0];
        if (run_r) restart_total = restart_total + 1;
        us_count = '0;
        fire_pt  = dly[tpaf_pkg::HalfW-1:0];
        end_pt   = dly[tpaf_pkg::HalfW-1:0] + width_r;
        run_r    = 1'b1;
      end
    end else if (run_r) begin
      us_count = us_count + 1'b1;
      if (us_count == fire_pt) begin
        gate_r     = 1'b1;
        fire_total = fire_total + 1;
      end
      if (us_count == end_pt) begin
        gate_r    = 1'b0;
        end_total = end_total + 1;
        run_r     = 1'b0;
      end
    end
    st.gate     = gate_r;
    st.delay    = delay_r;
    st.fires    = fire_total;
    st.ends     = end_total;
    st.restarts = restart_total;
    status_q.push_back(st);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag_mismatch(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    mismatches++;
    if (mismatches <= 25)
      $display("%0t: mismatch on %s, got %0h expected %0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    firing_status_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      results_seen++;
      if (status_q.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = status_q.pop_front();
        if (gate_o !== want.gate)
          flag_mismatch("gate", 32'(gate_o), 32'(want.gate));
        if (delay_us_o !== want.delay)
          flag_mismatch("delay_us", 32'(delay_us_o), 32'(want.delay));
        if (fire_count_o !== want.fires)
          flag_mismatch("fire_count", fire_count_o, want.fires);
        if (end_count_o !== want.ends) flag_mismatch("end_count", end_count_o, want.ends);
        if (restart_count_o !== want.restarts)
          flag_mismatch("restart_count", restart_count_o, want.restarts);
      end
    end
  end

  // ---------------------------------------------------------------- drivers

  // send one item, with a random idle gap first
  task automatic send_item(input logic op, input logic [tpaf_pkg::HalfW-1:0] half);
    int unsigned gap;
    gap = 0;
    while (gap < 40 && $urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    op_i             <= op;
    half_period_us_i <= half;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_firing(op, half);
    items_sent++;
    if (op == OpCrossing) crossings++;
  endtask

  task automatic tick_run(input int unsigned n);
    repeat (n) send_item(OpTick, 16'($urandom_range(0, 65535)));
  endtask

  // hold off until every result is back, then let the pipeline settle
  task automatic wait_settled();
    in_valid_i <= 1'b0;
    while (status_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [tpaf_pkg::HalfW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    apply_config(idx, val);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------- directed tests

  // disabled after reset: ticks, crossings and a write to the unused index change nothing
  task automatic test_after_reset();
    send_item(OpTick, 16'hFFFF);
    send_item(OpCrossing, 16'hFFFF);
    wait_settled();
    write_reg(CfgUnused, 16'hFFFF);
  endtask

  // half period at or below width + guard is ignored
  task automatic test_guard_band();
    write_reg(tpaf_pkg::CfgEnable, 16'h0001);
    write_reg(tpaf_pkg::CfgWidth, 16'd2);
    write_reg(tpaf_pkg::CfgAngle, 16'd0);
    send_item(OpCrossing, 16'd52);
    send_item(OpCrossing, 16'd0);
    wait_settled();
  endtask

  // upper bound below the 10 us floor wins; width change keeps armed points
  task automatic test_clamp_to_bound();
    send_item(OpCrossing, 16'd53);
    send_item(OpTick, 16'hA5A5);
    wait_settled();
    write_reg(tpaf_pkg::CfgWidth, 16'd40);
    tick_run(3);
    wait_settled();
  endtask

  // zero width: rise and fall on the same tick, gate ends low; angle above 180
  task automatic test_zero_width();
    write_reg(tpaf_pkg::CfgWidth, 16'd0);
    write_reg(tpaf_pkg::CfgAngle, 16'hFFFF);
    send_item(OpCrossing, 16'd51);
    send_item(OpTick, 16'h0000);
    wait_settled();
  endtask

  // crossing while the gate is high, then disable forces the gate low
  task automatic test_restart_in_pulse();
    write_reg(tpaf_pkg::CfgWidth, 16'd1);
    write_reg(tpaf_pkg::CfgAngle, 16'd90);
    send_item(OpCrossing, 16'd53);
    tick_run(2);
    send_item(OpCrossing, 16'd53);
    tick_run(2);
    wait_settled();
    write_reg(tpaf_pkg::CfgEnable, 16'hFFFE);
    send_item(OpTick, 16'hFFFF);
    wait_settled();
  endtask

  // widest half period and widest pulse width
  task automatic test_extremes();
    write_reg(tpaf_pkg::CfgEnable, 16'h0001);
    write_reg(tpaf_pkg::CfgWidth, 16'd0);
    write_reg(tpaf_pkg::CfgAngle, 16'd180);
    send_item(OpCrossing, 16'hFFFF);
    tick_run(2);
    wait_settled();
    write_reg(tpaf_pkg::CfgWidth, 16'hFFFF);
    send_item(OpCrossing, 16'hFFFF);
    send_item(OpTick, 16'h5A5A);
    wait_settled();
  endtask

  // ---------------------------------------------------------------- random traffic

  task automatic randomize_config();
    logic [tpaf_pkg::HalfW-1:0] v;
    int unsigned w;
    int unsigned a;
    case ($urandom_range(0, 9))
      0:       w = 0;
      1:       w = 65535;
      2:       w = $urandom_range(60, 150);
      default: w = $urandom_range(1, 40);
    endcase
    case ($urandom_range(0, 5))
      0:       a = 0;
      1:       a = 180;
      2:       a = $urandom_range(181, 255);
      default: a = $urandom_range(0, 180);
    endcase
    write_reg(tpaf_pkg::CfgWidth, w[tpaf_pkg::HalfW-1:0]);
    v = 16'($urandom);
    v[tpaf_pkg::AngleW-1:0] = a[tpaf_pkg::AngleW-1:0];
    write_reg(tpaf_pkg::CfgAngle, v);
    v = 16'($urandom);
    v[0] = ($urandom_range(0, 7) != 0);
    write_reg(tpaf_pkg::CfgEnable, v);
    if ($urandom_range(0, 7) == 0) write_reg(CfgUnused, 16'($urandom_range(0, 65535)));
  endtask

  // one crossing-led sequence; mostly full pulses, some cut short or noise
  task automatic run_sequence();
    int unsigned hp;
    logic [tpaf_pkg::HalfW-1:0] v;
    hp = width_r + 51 + $urandom_range(0, 120);
    if (hp > 65535) hp = 65535;
    case ($urandom_range(0, 9))
      0: repeat ($urandom_range(4, 12))
        send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)));
      1: begin
        hp = width_r + 50;
        if (hp > 65535) hp = 65535;
        send_item(OpCrossing, 16'($urandom_range(0, hp)));
        tick_run($urandom_range(1, 4));
      end
      2: begin
        send_item(OpCrossing, 16'($urandom_range(0, 65535)));
        tick_run($urandom_range(0, 40));
      end
      3: begin
        send_item(OpCrossing, hp[tpaf_pkg::HalfW-1:0]);
        tick_run(run_r ? $urandom_range(0, end_pt) : 1);
        wait_settled();
        v = 16'($urandom);
        v[0] = 1'b0;
        write_reg(tpaf_pkg::CfgEnable, v);
        tick_run(2);
        send_item(OpCrossing, hp[tpaf_pkg::HalfW-1:0]);
        wait_settled();
        v = 16'($urandom);
        v[0] = 1'b1;
        write_reg(tpaf_pkg::CfgEnable, v);
      end
      4: begin
        send_item(OpCrossing, hp[tpaf_pkg::HalfW-1:0]);
        tick_run(run_r ? $urandom_range(0, end_pt) : 1);
        send_item(OpCrossing, hp[tpaf_pkg::HalfW-1:0]);
        tick_run(run_r ? end_pt + $urandom_range(0, 3) : $urandom_range(1, 3));
      end
      default: begin
        send_item(OpCrossing, hp[tpaf_pkg::HalfW-1:0]);
        tick_run(run_r ? end_pt + $urandom_range(0, 3) : $urandom_range(1, 3));
      end
    endcase
  endtask

  task automatic test_random_traffic(input int unsigned n_items, input int unsigned idle_pct,
                                     input int unsigned hold_pct);
    int unsigned start;
    send_idle_pct = idle_pct;
    stall_pct     = hold_pct;
    start         = items_sent;
    while (items_sent - start < n_items) begin
      wait_settled();
      randomize_config();
      repeat ($urandom_range(1, 4)) run_sequence();
    end
    wait_settled();
  endtask

  // ---------------------------------------------------------------- sequence

  initial begin
    reset_firing_state();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_after_reset();
    test_guard_band();
    test_clamp_to_bound();
    test_zero_width();
    test_restart_in_pulse();
    test_extremes();

    test_random_traffic(320, 0, 0);
    test_random_traffic(310, 82, 0);
    test_random_traffic(310, 0, 82);
    test_random_traffic(310, 22, 22);

    wait_settled();
    repeat (8) @(posedge clk_i);
    $display("Sent %0d items (%0d zero crossings), checked %0d results across",
             items_sent, crossings, results_seen);
    $display("directed cases and four idle/stall mixes: %0d fires, %0d ends, %0d restarts.",
             fire_total, end_total, restart_total);
    if (mismatches == 0 && status_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// File: files.f
src/tpaf_pkg.sv
src/tpaf_delay.sv
src/thyristor_phase_angle_firing_top.sv
bench/tb_thyristor_phase_angle_firing_top.sv
